// ===== rtl/huber_loss_and_gradient_top_macros.svh =====
// assertion macros shared by the huber loss rtl
`ifndef HUBER_LOSS_AND_GRADIENT_TOP_MACROS_SVH
`define HUBER_LOSS_AND_GRADIENT_TOP_MACROS_SVH

// clocked assertion, quiet while reset is held
`define HLG_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// clocked assertion that also holds during reset
`define HLG_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ===== rtl/hlg_pkg.sv =====
// types, constants and codes of the huber loss and gradient block
package hlg_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int ACC_BITS    = 48;
    localparam int DELTA_W     = 16;
    localparam int N_W         = 13;
    localparam int GRAD_W      = 17;
    localparam int MEAN_W      = 48;
    localparam int E_W         = SAMPLE_BITS + 1;
    localparam int CMP_W       = (E_W > DELTA_W) ? E_W : DELTA_W;
    localparam int TERM_W      = 2 * CMP_W;
    localparam int SUM_W       = ((ACC_BITS > TERM_W) ? ACC_BITS : TERM_W) + 1;
    localparam int STEP_W      = $clog2(ACC_BITS + 1);
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_IDX_W-1:0] REG_HUBER_DELTA = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BATCH_ROWS  = 2'd1;

    localparam logic [DELTA_W-1:0] DELTA_RESET = 16'd256;
    localparam logic [N_W-1:0]     ROWS_RESET  = 13'd1;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] pred_value;
        logic signed [SAMPLE_BITS-1:0] target_value;
        logic                          last_element;
    } t_in_item;

    typedef struct packed {
        logic signed [GRAD_W-1:0] gradient;
        logic [MEAN_W-1:0]        avg_loss;
        logic                     final_res;
    } t_out_item;

    typedef struct packed {
        logic                start;
        logic [ACC_BITS-1:0] dividend;
        logic [STEP_W-1:0]   steps;
        logic [N_W-1:0]      divisor;
    } t_div_req;

    typedef struct packed {
        logic                done;
        logic [ACC_BITS-1:0] quotient;
    } t_div_rsp;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_MUL  = 6'b000010,
        S_ACC  = 6'b000100,
        S_GDIV = 6'b001000,
        S_MDIV = 6'b010000,
        S_FIN  = 6'b100000
    } t_state;

endpackage

// ===== rtl/hlg_div.sv =====
// shared restoring divider, one quotient bit per cycle
module hlg_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  hlg_pkg::t_div_req i_req,
    output hlg_pkg::t_div_rsp o_rsp
);
    import hlg_pkg::*;

    logic                r_busy;
    logic                r_done;
    logic [STEP_W-1:0]   r_cnt;
    logic [N_W-1:0]      r_rem;
    logic [N_W-1:0]      r_div;
    logic [ACC_BITS-1:0] r_quo;

    logic [N_W:0]   trial;
    logic [N_W:0]   trial_sub;
    logic           ge;
    logic [N_W-1:0] n_rem;

    always_comb begin
        trial     = {r_rem, r_quo[ACC_BITS-1]};
        trial_sub = trial - {1'b0, r_div};
        ge        = (trial >= {1'b0, r_div});
        n_rem     = ge ? trial_sub[N_W-1:0] : trial[N_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_req.steps;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == STEP_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // payload, no reset
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_quo <= i_req.dividend;
            r_rem <= '0;
            r_div <= i_req.divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[ACC_BITS-2:0], ge};
            r_rem <= n_rem;
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

endmodule

// ===== rtl/huber_loss_and_gradient_top.sv =====
// top level of the huber loss and gradient block: sequencer, accumulator, output register
// Each pair accepted on the input channel yields one result transaction, and no new pair
// is taken until the sequencer is back in idle. The steps are: capture and compare as the
// pair is taken, the square or linear product, the saturating add, the gradient divide
// state (division by N; the divider's first step overlaps the add and its done cycle ends
// the state), and the hand-over of the result to the output register. A pair flagged
// last_element adds a second division of the running sum for the mean; the sum is cleared
// as that division starts. The one restoring divider serves both divisions. The input stall
// is high whenever the sequencer is busy; a finished result waits in the output register
// while the next pair is taken, and a result that finds the output register still stalled
// holds the sequencer until it drains. A batch_rows value of 0 divides by 1.
`include "huber_loss_and_gradient_top_macros.svh"

module huber_loss_and_gradient_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // input channel
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  hlg_pkg::t_in_item                   i_in_data,
    // output channel
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output hlg_pkg::t_out_item                  o_out_data,
    // configuration write port
    input  logic                                i_cfg_we,
    input  logic [hlg_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [hlg_pkg::CFG_DATA_W-1:0]      i_cfg_data
);
    import hlg_pkg::*;

    // configuration registers
    logic [DELTA_W-1:0] r_delta;
    logic [N_W-1:0]     r_rows;

    // sequencer and running sum
    t_state              r_state;
    logic [ACC_BITS-1:0] r_loss_sum;

    // per-transaction working registers
    logic [CMP_W-1:0]   r_e;
    logic [CMP_W-1:0]   r_d;
    logic               r_lin;
    logic               r_neg;
    logic               r_last;
    logic [N_W-1:0]     r_n;
    logic [TERM_W-1:0]  r_term;
    logic [GRAD_W-1:0]  r_grad;
    logic [MEAN_W-1:0]  r_mean;

    // output register
    logic               r_out_valid;
    t_out_item          r_out;

    t_div_req div_req;
    t_div_rsp div_rsp;

    logic in_accept;
    logic out_accept;
    logic out_load;

    // capture arithmetic: err magnitude and regime
    logic signed [E_W-1:0] cap_diff;
    logic [E_W-1:0]        cap_abs;
    logic [CMP_W-1:0]      cap_e;
    logic [CMP_W-1:0]      cap_d;

    // multiply operands
    logic [CMP_W-1:0]      mul_a;
    logic [CMP_W:0]        mul_b;
    logic [TERM_W:0]       mul_p;

    // saturating add
    logic [SUM_W-1:0]      sum_wide;
    logic [ACC_BITS-1:0]   sum_sat;

    // gradient and mean from divider
    logic [DELTA_W-1:0]           grad_mag;
    logic [GRAD_W-1:0]            grad_pos;
    logic [MEAN_W+ACC_BITS-1:0]   quo_ext;
    logic [MEAN_W-1:0]            mean_sat;

    assign in_accept  = i_in_valid && !o_in_stall;
    assign out_accept = r_out_valid && !i_out_stall;
    assign out_load   = (r_state == S_FIN) && (!r_out_valid || !i_out_stall);
    assign o_in_stall = (r_state != S_IDLE);

    always_comb begin
        cap_diff = E_W'(i_in_data.pred_value) - E_W'(i_in_data.target_value);
        cap_abs  = cap_diff[E_W-1] ? E_W'(-cap_diff) : E_W'(cap_diff);
        cap_e    = CMP_W'(cap_abs);
        cap_d    = CMP_W'(r_delta);
    end

    // quadratic: e*e, linear: d*(2e-d); the halving is the drop of the low bit
    always_comb begin
        mul_a = r_lin ? r_d : r_e;
        mul_b = r_lin ? (({r_e, 1'b0}) - {1'b0, r_d}) : {1'b0, r_e};
        mul_p = (TERM_W + 1)'(mul_a) * (TERM_W + 1)'(mul_b);
    end

    always_comb begin
        sum_wide = SUM_W'(r_loss_sum) + SUM_W'(r_term);
        sum_sat  = (|sum_wide[SUM_W-1:ACC_BITS]) ? {ACC_BITS{1'b1}}
                                                 : sum_wide[ACC_BITS-1:0];
    end

    // gradient numerator magnitude fits the delta width in both regimes
    assign grad_mag = r_lin ? r_d[DELTA_W-1:0] : r_e[DELTA_W-1:0];

    always_comb begin
        grad_pos = GRAD_W'(div_rsp.quotient[DELTA_W-1:0]);
        quo_ext  = (MEAN_W + ACC_BITS)'(div_rsp.quotient);
        mean_sat = (|quo_ext[MEAN_W+ACC_BITS-1:MEAN_W]) ? {MEAN_W{1'b1}}
                                                        : quo_ext[MEAN_W-1:0];
    end

    // divider requests: gradient with the product, mean after the gradient of a last pair
    always_comb begin
        div_req.start    = 1'b0;
        div_req.dividend = {grad_mag, {(ACC_BITS-DELTA_W){1'b0}}};
        div_req.steps    = STEP_W'(DELTA_W);
        div_req.divisor  = r_n;
        if (r_state == S_MUL) begin
            div_req.start = 1'b1;
        end else if ((r_state == S_GDIV) && div_rsp.done && r_last) begin
            div_req.start    = 1'b1;
            div_req.dividend = r_loss_sum;
            div_req.steps    = STEP_W'(ACC_BITS);
        end
    end

    hlg_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_loss_sum  <= '0;
            r_delta     <= DELTA_RESET;
            r_rows      <= ROWS_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_HUBER_DELTA: r_delta <= i_cfg_data[DELTA_W-1:0];
                    REG_BATCH_ROWS:  r_rows  <= i_cfg_data[N_W-1:0];
                    default: ;
                endcase
            end

            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (out_accept) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (in_accept) begin
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_state <= S_ACC;
                end
                S_ACC: begin
                    r_loss_sum <= sum_sat;
                    r_state    <= S_GDIV;
                end
                S_GDIV: begin
                    if (div_rsp.done) begin
                        if (r_last) begin
                            // divider holds its own copy of the sum
                            r_loss_sum <= '0;
                            r_state    <= S_MDIV;
                        end else begin
                            r_state <= S_FIN;
                        end
                    end
                end
                S_MDIV: begin
                    if (div_rsp.done) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (out_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_e    <= cap_e;
            r_d    <= cap_d;
            r_lin  <= (cap_e > cap_d);
            r_neg  <= cap_diff[E_W-1];
            r_last <= i_in_data.last_element;
            r_n    <= (r_rows == '0) ? N_W'(1) : r_rows;
        end
        if (r_state == S_MUL) begin
            r_term <= mul_p[TERM_W:1];
        end
        if ((r_state == S_GDIV) && div_rsp.done) begin
            // truncation toward zero: divide the magnitude, then restore the sign
            r_grad <= r_neg ? GRAD_W'(-grad_pos) : grad_pos;
            r_mean <= '0;
        end
        if ((r_state == S_MDIV) && div_rsp.done) begin
            r_mean <= mean_sat;
        end
        if (out_load) begin
            r_out.gradient  <= r_grad;
            r_out.avg_loss  <= r_mean;
            r_out.final_res <= r_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // the divider only reports while the sequencer waits for it
    `HLG_ASSERT(a_div_done_when_waiting, div_rsp.done |-> (r_state == S_GDIV || r_state == S_MDIV), "divider done outside a divide state")
    // a result that is not final carries no mean
    `HLG_ASSERT(a_mean_zero_not_final, (o_out_valid && !o_out_data.final_res) |-> (o_out_data.avg_loss == '0), "mean set on a non-final result")
    // the running sum is cleared once the mean division starts
    `HLG_ASSERT(a_sum_cleared_on_last, (r_state == S_GDIV && div_rsp.done && r_last) |=> (r_loss_sum == '0), "sum not cleared after last pair")
    // no new divide starts while the block waits on the mean division
    `HLG_ASSERT(a_no_start_in_mdiv, (r_state == S_MDIV) |-> !div_req.start, "divider restarted during mean division")

endmodule
